### rtl/pcsrx_pkg.sv
// Shared types and constants for the PCS receive decoder with covert extraction.
package pcsrx_pkg;

    // Receive state, also driven out as link_state
    typedef enum logic [2:0] {
        ST_INIT = 3'd0,
        ST_CTRL = 3'd1,
        ST_DATA = 3'd2,
        ST_TERM = 3'd3,
        ST_ERR  = 3'd4
    } link_state_t;

    localparam int HIST_W = 58;
    localparam int LIMIT_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 58;

    localparam int COVERT_BUFFER_BYTES = 128;
    // Byte position must be able to hold the buffer size itself
    localparam int CPOS_W = $clog2(COVERT_BUFFER_BYTES + 1);
    localparam int CIDX_W = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEED  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT = 2'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(COVERT_BUFFER_BYTES);

    localparam logic [1:0] SH_DATA = 2'd2;

    // Descrambler taps x^58 + x^39 + 1
    localparam int TAP_A = 38;
    localparam int TAP_B = 57;

    // Control block type codes
    localparam logic [7:0] BT_START4_C = 8'h33;
    localparam logic [7:0] BT_START4   = 8'h66;
    localparam logic [7:0] BT_START7   = 8'h78;
    localparam logic [7:0] BT_TERM0    = 8'h87;
    localparam logic [7:0] BT_TERM1    = 8'h99;
    localparam logic [7:0] BT_TERM2    = 8'haa;
    localparam logic [7:0] BT_TERM3    = 8'hb4;
    localparam logic [7:0] BT_TERM4    = 8'hcc;
    localparam logic [7:0] BT_TERM5    = 8'hd2;
    localparam logic [7:0] BT_TERM6    = 8'he1;
    localparam logic [7:0] BT_TERM7    = 8'hff;
    localparam logic [7:0] BT_CTRL_1E  = 8'h1e;
    localparam logic [7:0] BT_CTRL_2D  = 8'h2d;
    localparam logic [7:0] BT_CTRL_4B  = 8'h4b;
    localparam logic [7:0] BT_CTRL_55  = 8'h55;

endpackage

### rtl/pcs_rx_decode_covert_extract_top.sv
// Top level: 64b/66b receive descrambler, block decoder and covert byte extractor.
//
// One 66-bit block is taken per request on the input channel and one result per
// block comes out on the output channel. A block is accepted in every cycle in
// which the result register is empty or its result is being taken, so the block
// sustains one block per clock; each result is valid in the cycle after acceptance.
// All work (64-bit self-synchronizing descrambler, type decode, receive
// state update and covert bit packing) is a single pass of combinational logic
// between the input ports and the result register; the descrambler history,
// receive state and covert packing state are updated at the accepting edge.
// Configuration: index 0 loads the 58-bit descrambler history immediately;
// index 1 sets the covert byte limit (clamped to the 128-byte buffer); other
// indexes are ignored. Write configuration only while no block is in flight.
module pcs_rx_decode_covert_extract_top
    import pcsrx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // block input
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             sync_header,
    input  logic [63:0]            payload,
    // result output
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [63:0]            data_word,
    output logic [3:0]             data_bytes,
    output logic                   frame_start,
    output logic                   frame_end,
    output logic                   block_error,
    output logic [2:0]             link_state,
    output logic [2:0]             covert_bits_taken,
    output logic                   covert_byte_valid,
    output logic [7:0]             covert_byte,
    output logic [CIDX_W-1:0]      covert_byte_index
);

    // ---------------- state ----------------
    logic [HIST_W-1:0]  hist_reg;
    link_state_t        state_reg;
    logic [CPOS_W-1:0]  cpos_reg;
    logic [2:0]         cbit_reg;
    logic [7:0]         cpart_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg;

    // result registers
    logic [63:0]        word_reg;
    logic [3:0]         nbytes_reg;
    logic               start_reg;
    logic               end_reg;
    logic               err_reg;
    logic [2:0]         taken_reg;
    logic               cvalid_reg;
    logic [7:0]         cbyte_reg;
    logic [CIDX_W-1:0]  cidx_reg;

    // ---------------- next values ----------------
    logic [HIST_W-1:0]  hist_next;
    link_state_t        state_next;
    logic [CPOS_W-1:0]  cpos_next;
    logic [2:0]         cbit_next;
    logic [7:0]         cpart_next;

    logic [63:0]        word_next;
    logic [3:0]         nbytes_next;
    logic               start_next;
    logic               end_next;
    logic               err_next;
    logic [2:0]         taken_next;
    logic               cvalid_next;
    logic [7:0]         cbyte_next;
    logic [CIDX_W-1:0]  cidx_next;

    logic               accept;
    logic [63:0]        desc;
    logic [7:0]         btype;
    logic [6:0]         cdata;
    logic [2:0]         ccnt;
    logic               is_term;
    logic [2:0]         tail;
    logic [LIMIT_W-1:0] lim_eff;
    logic [3:0]         ctotal;
    logic [63:0]        tail_mask;
    logic               open_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Descrambler: the received stream, oldest history bit first, then this
    // payload, sits in one vector, so each tap is a fixed offset behind the bit.
    always_comb
    begin
        logic [HIST_W+63:0] bit_seq;
        for (int k = 0; k < HIST_W; k++)
        begin
            bit_seq[HIST_W-1-k] = hist_reg[k];
        end
        bit_seq[HIST_W+63:HIST_W] = payload;
        for (int i = 0; i < 64; i++)
        begin
            desc[i] = payload[i] ^ bit_seq[i + HIST_W - 1 - TAP_A]
                                 ^ bit_seq[i + HIST_W - 1 - TAP_B];
        end
        // after 64 bits the history holds the last 58 received bits, newest in bit 0
        for (int k = 0; k < HIST_W; k++)
        begin
            hist_next[k] = payload[63-k];
        end
    end

    assign btype = desc[7:0];

    // Covert bit field and terminate byte count per block type
    always_comb
    begin
        cdata   = 7'd0;
        ccnt    = 3'd0;
        is_term = 1'b0;
        tail    = 3'd0;
        unique case (btype)
            BT_START4_C: begin cdata = {3'd0, desc[39:36]}; ccnt = 3'd4; end
            BT_TERM0:
            begin
                cdata = desc[14:8]; ccnt = 3'd7; is_term = 1'b1; tail = 3'd0;
            end
            BT_TERM1:
            begin
                cdata = {1'b0, desc[21:16]}; ccnt = 3'd6; is_term = 1'b1; tail = 3'd1;
            end
            BT_TERM2:
            begin
                cdata = {2'd0, desc[28:24]}; ccnt = 3'd5; is_term = 1'b1; tail = 3'd2;
            end
            BT_TERM3:
            begin
                cdata = {3'd0, desc[35:32]}; ccnt = 3'd4; is_term = 1'b1; tail = 3'd3;
            end
            BT_TERM4:
            begin
                cdata = {4'd0, desc[42:40]}; ccnt = 3'd3; is_term = 1'b1; tail = 3'd4;
            end
            BT_TERM5:
            begin
                cdata = {5'd0, desc[49:48]}; ccnt = 3'd2; is_term = 1'b1; tail = 3'd5;
            end
            BT_TERM6:
            begin
                cdata = {6'd0, desc[56]}; ccnt = 3'd1; is_term = 1'b1; tail = 3'd6;
            end
            BT_TERM7:    begin is_term = 1'b1; tail = 3'd7; end
            default:     ;
        endcase
    end

    assign lim_eff   = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;
    assign ctotal    = {1'b0, cbit_reg} + {1'b0, ccnt};
    assign tail_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {tail, 3'b000});
    assign open_ok   = (state_reg != ST_DATA);

    // Covert packing
    always_comb
    begin
        logic [7:0] shifted;
        shifted     = 8'({1'b0, cdata} << cbit_reg);
        cpos_next   = cpos_reg;
        cbit_next   = cbit_reg;
        cpart_next  = cpart_reg;
        taken_next  = 3'd0;
        cvalid_next = 1'b0;
        cbyte_next  = 8'd0;
        cidx_next   = '0;
        if (sync_header != SH_DATA)
        begin
            priority if (cpos_reg >= lim_eff)
            begin
                // limit reached: drop this block's bits and restart
                cpos_next  = '0;
                cbit_next  = 3'd0;
                cpart_next = 8'd0;
            end
            else if (ccnt != 3'd0)
            begin
                taken_next = ccnt;
                if (ctotal >= 4'd8)
                begin
                    cvalid_next = 1'b1;
                    cbyte_next  = cpart_reg | shifted;
                    cidx_next   = cpos_reg[CIDX_W-1:0];
                    cpos_next   = cpos_reg + CPOS_W'(1);
                    cpart_next  = 8'({1'b0, cdata} >> (4'd8 - {1'b0, cbit_reg}));
                    cbit_next   = 3'(ctotal - 4'd8);
                end
                else
                begin
                    cpart_next = cpart_reg | shifted;
                    cbit_next  = ctotal[2:0];
                end
            end
        end
    end

    // Block classification and receive state
    always_comb
    begin
        state_next  = state_reg;
        word_next   = 64'd0;
        nbytes_next = 4'd0;
        start_next  = 1'b0;
        end_next    = 1'b0;
        err_next    = 1'b0;
        if (sync_header == SH_DATA)
        begin
            if (state_reg == ST_DATA || state_reg == ST_ERR)
            begin
                word_next   = desc;
                nbytes_next = 4'd8;
            end
            else
                err_next = 1'b1;
        end
        else
        begin
            priority if (is_term)
            begin
                if (state_reg == ST_DATA)
                begin
                    word_next   = (desc >> 8) & tail_mask;
                    nbytes_next = {1'b0, tail};
                    end_next    = 1'b1;
                    state_next  = ST_TERM;
                end
                else
                    err_next = 1'b1;
            end
            else if (btype == BT_START4_C || btype == BT_START4 || btype == BT_START7)
            begin
                if (open_ok)
                begin
                    word_next   = (btype == BT_START7) ? (desc >> 8) : (desc >> 32);
                    nbytes_next = (btype == BT_START7) ? 4'd7 : 4'd4;
                    start_next  = 1'b1;
                    state_next  = ST_DATA;
                end
                else
                    err_next = 1'b1;
            end
            else if (btype == BT_CTRL_1E || btype == BT_CTRL_2D ||
                     btype == BT_CTRL_4B || btype == BT_CTRL_55)
            begin
                if (open_ok)
                    state_next = ST_CTRL;
                else
                    err_next = 1'b1;
            end
            else
                err_next = 1'b1;
        end
        if (err_next)
            state_next = ST_ERR;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            state_reg     <= ST_INIT;
            cpos_reg      <= '0;
            cbit_reg      <= 3'd0;
            cpart_reg     <= 8'd0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_SEED)
                hist_reg <= cfg_data[HIST_W-1:0];
            else if (accept)
                hist_reg <= hist_next;
            if (cfg_write && cfg_index == CFG_LIMIT)
                limit_reg <= cfg_data[LIMIT_W-1:0];
            if (accept)
            begin
                state_reg <= state_next;
                cpos_reg  <= cpos_next;
                cbit_reg  <= cbit_next;
                cpart_reg <= cpart_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg   <= word_next;
            nbytes_reg <= nbytes_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            err_reg    <= err_next;
            taken_reg  <= taken_next;
            cvalid_reg <= cvalid_next;
            cbyte_reg  <= cbyte_next;
            cidx_reg   <= cidx_next;
        end
    end

    // link_state shows the state reached by the block in the result register
    assign out_valid         = out_valid_reg;
    assign data_word         = word_reg;
    assign data_bytes        = nbytes_reg;
    assign frame_start       = start_reg;
    assign frame_end         = end_reg;
    assign block_error       = err_reg;
    assign link_state        = state_reg;
    assign covert_bits_taken = taken_reg;
    assign covert_byte_valid = cvalid_reg;
    assign covert_byte       = cbyte_reg;
    assign covert_byte_index = cidx_reg;

endmodule

### rtl/pcsrx_checker.sv
// Port-level checker for the PCS receive decoder, bound to the top level.
module pcsrx_checker
    import pcsrx_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [63:0]       data_word,
    input logic [3:0]        data_bytes,
    input logic              frame_start,
    input logic              frame_end,
    input logic              block_error,
    input logic [2:0]        link_state,
    input logic              covert_byte_valid,
    input logic [7:0]        covert_byte,
    input logic [CIDX_W-1:0] covert_byte_index
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_word) && $stable(link_state))
        else $error("result changed while stalled");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_error |-> link_state == ST_ERR && data_bytes == 4'd0 &&
            !frame_start && !frame_end)
        else $error("error block with data or wrong state");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start |-> link_state == ST_DATA &&
            (data_bytes == 4'd4 || data_bytes == 4'd7))
        else $error("bad start result");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> link_state == ST_TERM && data_bytes < 4'd8)
        else $error("bad terminate result");

    a_covert: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !covert_byte_valid |-> covert_byte == 8'd0 && covert_byte_index == '0)
        else $error("covert byte fields set without a byte");

endmodule

bind pcs_rx_decode_covert_extract_top pcsrx_checker u_pcsrx_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .data_word         (data_word),
    .data_bytes        (data_bytes),
    .frame_start       (frame_start),
    .frame_end         (frame_end),
    .block_error       (block_error),
    .link_state        (link_state),
    .covert_byte_valid (covert_byte_valid),
    .covert_byte       (covert_byte),
    .covert_byte_index (covert_byte_index)
);
